// ===== hw/rtl/bounding_volume_box_classify_macros.svh =====
// Assertion macros shared by the bounding volume box classifier RTL.
`ifndef BOUNDING_VOLUME_BOX_CLASSIFY_MACROS_SVH
`define BOUNDING_VOLUME_BOX_CLASSIFY_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst is high.
`define BVBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst is high.
`define BVBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bvbc_pkg.sv =====
// Result codes and mode codes of the bounding volume box classifier.
package bvbc_pkg;

  localparam int REL_BITS = 2;

  typedef enum logic [REL_BITS-1:0] {
    REL_OUTSIDE   = 2'd0,
    REL_INTERSECT = 2'd1,
    REL_INSIDE    = 2'd2
  } relation_t;

  localparam logic MODE_SPHERE  = 1'b0;
  localparam logic MODE_CAPSULE = 1'b1;

  // Result items are padded to a whole byte.
  localparam int RESULT_BYTES_BITS = 8;

endpackage

// ===== hw/rtl/bounding_volume_box_classify.sv =====
// Each accepted item passes the input, gap, square and output registers to reach m_tdata.
// Throughput: one item per cycle unless the output stalls; four register stages (input,
// gaps and compares, squares, sum and decision) each hand over to the next whenever it
// can take more. A stalled result holds the output register; upstream stages keep filling.
// Reset (rst, synchronous) clears all stage valid bits; no item state survives it.
// No clearing pass or warm-up is needed after reset.
`include "bounding_volume_box_classify_macros.svh"

module bounding_volume_box_classify
  import bvbc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields, low bit up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
  // box_max_z, shape_x, shape_y, shape_z, shape_radius, shape_height, zero pad.
  input  logic [((9*COORD_BITS+2*(COORD_BITS-1)+7)/8)*8-1:0] s_tdata,
  // Fields: mode (0 sphere, 1 upright capsule).
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields, low bit up: relation, zero pad.
  output logic [RESULT_BYTES_BITS-1:0] m_tdata
);

  // Coordinate width, radius/height width, and one bit of headroom so that
  // sums like base plus radius can never wrap.
  localparam int CW   = COORD_BITS;
  localparam int UW   = COORD_BITS - 1;
  localparam int WW   = COORD_BITS + 1;
  localparam int FB   = 9*COORD_BITS + 2*(COORD_BITS-1);
  // A gap is kept at the radius width; one past the radius already decides outside,
  // so only gaps within the radius matter, and a square fits twice that width.
  localparam int SQW  = 2*UW;
  // Six squares are summed (an inverted box may add both gaps of one axis).
  localparam int SUMW = SQW + 3;
  localparam int AXES = 3;
  localparam int GAPS = 2*AXES;

  // ---------------------------------------------------------------------
  // Stage handshake: each stage loads when it is empty or its successor
  // is loading as well.
  // ---------------------------------------------------------------------
  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready, d_ready;

  assign d_ready  = !m_tvalid || m_tready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  // ---------------------------------------------------------------------
  // Stage A: input register.
  // ---------------------------------------------------------------------
  logic [FB-1:0] a_data;
  logic          a_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
    if (a_ready && s_tvalid) begin
      a_data <= s_tdata[FB-1:0];
      a_mode <= s_tuser;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B logic: per-axis gaps for the sphere test, strict containment
  // for the sphere inside case, and the whole capsule-as-box overlap test.
  // ---------------------------------------------------------------------
  logic signed [WW-1:0] bmin_w [AXES];
  logic signed [WW-1:0] bmax_w [AXES];
  logic signed [WW-1:0] ctr_w  [AXES];
  logic signed [WW-1:0] cmin_w [AXES];
  logic signed [WW-1:0] cmax_w [AXES];
  logic signed [WW-1:0] lo_gap [AXES];
  logic signed [WW-1:0] hi_gap [AXES];
  logic        [UW-1:0] rad;
  logic        [UW-1:0] hgt;
  logic signed [WW-1:0] rad_w;
  logic signed [WW-1:0] hgt_w;
  logic        [UW-1:0] gap_n  [GAPS];
  logic                 over_n;
  logic                 inside_n;
  logic                 overlap_all;
  logic                 cap_holds_box;
  logic                 box_holds_cap;
  relation_t            cap_rel_n;

  always_comb begin
    rad   = a_data[9*CW +: UW];
    hgt   = a_data[9*CW+UW +: UW];
    rad_w = $signed({2'b00, rad});
    hgt_w = $signed({2'b00, hgt});
    over_n        = 1'b0;
    inside_n      = 1'b1;
    overlap_all   = 1'b1;
    cap_holds_box = 1'b1;
    box_holds_cap = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      bmin_w[i] = $signed({a_data[i*CW+CW-1], a_data[i*CW +: CW]});
      bmax_w[i] = $signed({a_data[(3+i)*CW+CW-1], a_data[(3+i)*CW +: CW]});
      ctr_w[i]  = $signed({a_data[(6+i)*CW+CW-1], a_data[(6+i)*CW +: CW]});

      // Sphere: a gap counts when the center is below the minimum or above
      // the maximum; any single gap past the radius decides outside.
      lo_gap[i] = bmin_w[i] - ctr_w[i];
      hi_gap[i] = ctr_w[i] - bmax_w[i];
      gap_n[2*i]   = '0;
      gap_n[2*i+1] = '0;
      if (ctr_w[i] < bmin_w[i]) begin
        gap_n[2*i] = lo_gap[i][UW-1:0];
        if (lo_gap[i] > rad_w) over_n = 1'b1;
      end
      if (ctr_w[i] > bmax_w[i]) begin
        gap_n[2*i+1] = hi_gap[i][UW-1:0];
        if (hi_gap[i] > rad_w) over_n = 1'b1;
      end
      if (!(ctr_w[i] > bmin_w[i] + rad_w && ctr_w[i] < bmax_w[i] - rad_w)) begin
        inside_n = 1'b0;
      end

      // Capsule: the y axis runs from the base up by the height, with no
      // radius below the base; x and z reach the radius both ways.
      if (i == 1) begin
        cmin_w[i] = ctr_w[i];
        cmax_w[i] = ctr_w[i] + hgt_w;
      end else begin
        cmin_w[i] = ctr_w[i] - rad_w;
        cmax_w[i] = ctr_w[i] + rad_w;
      end
      if (!(cmax_w[i] >= bmin_w[i] && cmin_w[i] <= bmax_w[i])) overlap_all = 1'b0;
      if (!(cmax_w[i] >= bmax_w[i] && cmin_w[i] <= bmin_w[i])) cap_holds_box = 1'b0;
      if (!(bmax_w[i] >= cmax_w[i] && bmin_w[i] <= cmin_w[i])) box_holds_cap = 1'b0;
    end
    if (!overlap_all) begin
      cap_rel_n = REL_OUTSIDE;
    end else if (cap_holds_box || box_holds_cap) begin
      cap_rel_n = REL_INSIDE;
    end else begin
      cap_rel_n = REL_INTERSECT;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B registers.
  // ---------------------------------------------------------------------
  logic [UW-1:0] b_gap [GAPS];
  logic [UW-1:0] b_rad;
  logic          b_capsule;
  logic          b_over;
  logic          b_inside;
  relation_t     b_cap_rel;
  logic          b_gap_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_gap     <= gap_n;
      b_rad     <= rad;
      b_capsule <= (a_mode == MODE_CAPSULE);
      b_over    <= over_n;
      b_inside  <= inside_n;
      b_cap_rel <= cap_rel_n;
    end
  end

  always_comb begin
    b_gap_any = 1'b0;
    for (int k = 0; k < GAPS; k++) begin
      b_gap_any = b_gap_any | (|b_gap[k]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: squares of the gaps and of the radius, all in parallel.
  // ---------------------------------------------------------------------
  logic [SQW-1:0] c_sq [GAPS];
  logic [SQW-1:0] c_rad_sq;
  logic           c_capsule;
  logic           c_over;
  logic           c_inside;
  relation_t      c_cap_rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
    if (c_ready && b_valid) begin
      for (int k = 0; k < GAPS; k++) begin
        c_sq[k] <= SQW'(b_gap[k] * b_gap[k]);
      end
      c_rad_sq  <= SQW'(b_rad * b_rad);
      c_capsule <= b_capsule;
      c_over    <= b_over;
      c_inside  <= b_inside;
      c_cap_rel <= b_cap_rel;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: sum of squares against the squared radius, final decision,
  // into the output register. Touching (sum equal) counts as intersecting.
  // ---------------------------------------------------------------------
  logic [SUMW-1:0] sq_sum;
  relation_t       sph_rel;
  relation_t       rel_next;

  always_comb begin
    sq_sum = '0;
    for (int k = 0; k < GAPS; k++) begin
      sq_sum = sq_sum + SUMW'(c_sq[k]);
    end
    if (c_over || sq_sum > SUMW'(c_rad_sq)) begin
      sph_rel = REL_OUTSIDE;
    end else if (c_inside) begin
      sph_rel = REL_INSIDE;
    end else begin
      sph_rel = REL_INTERSECT;
    end
    rel_next = c_capsule ? c_cap_rel : sph_rel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (d_ready) begin
      m_tvalid <= c_valid;
    end
    if (d_ready && c_valid) begin
      m_tdata <= {{(RESULT_BYTES_BITS-REL_BITS){1'b0}}, rel_next};
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A sphere strictly inside every face can have no gap on any axis.
  `BVBC_ASSERT_NOW(a_inside_no_gap, b_valid && !b_capsule && b_inside, !b_over && !b_gap_any, "sphere inside with a nonzero gap")
  // With the output register free, the whole pipe must be able to take an item.
  `BVBC_ASSERT_NOW(a_empty_out_ready, !m_tvalid, s_tready, "input stalled with output register empty")
  // A result appears only from an item that sat in the square stage.
  `BVBC_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(c_valid), "result without a source item")
  // An accepted item always lands in the input register.
  `BVBC_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, a_valid, "accepted item lost at input")

endmodule
